// ===== src/crc_block_framer_with_xor_parity_assert.svh =====
// Assertion macros shared by the framer RTL
`ifndef CRC_BLOCK_FRAMER_WITH_XOR_PARITY_ASSERT_SVH
`define CRC_BLOCK_FRAMER_WITH_XOR_PARITY_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define CRCBF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define CRCBF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/crcbf_pkg.sv =====
// Shared types, constants and functions of the CRC block framer
package crcbf_pkg;

	localparam int MAX_BITS_DEF = 16;
	localparam int HDR_LEN = 8;
	localparam logic [4:0] BITS_RESET = 5'd12;
	localparam logic [4:0] BITS_MIN = 5'd6;
	localparam logic [31:0] CRC_POLY = 32'h82F63B78;

	// Byte source selected in the output stage
	typedef enum logic [1:0] {
		SRC_LIT,
		SRC_CRC,
		SRC_PAR
	} src_t;

	// One output byte operation from the sequencer
	typedef struct packed {
		logic [7:0] lit;
		src_t src;
		logic [1:0] crc_k;
		logic framed;
		logic par_we;
		logic last;
		logic done;
	} op_t;

	// CRC-32C over one byte, kept in finished (inverted) form
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = ~crc;
		c[7:0] = c[7:0] ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return ~c;
	endfunction

	// Header text "CRc 0NN\n" for block bits between 6 and 16
	function automatic logic [7:0] hdr_byte(input logic [2:0] idx, input logic [4:0] eb);
		logic [7:0] r;
		case (idx)
			3'd0: r = 8'h43;
			3'd1: r = 8'h52;
			3'd2: r = 8'h63;
			3'd3: r = 8'h20;
			3'd4: r = 8'h30;
			3'd5: r = (eb >= 5'd10) ? 8'h31 : 8'h30;
			3'd6: r = 8'h30 + 8'((eb >= 5'd10) ? (eb - 5'd10) : eb);
			default: r = 8'h0A;
		endcase
		return r;
	endfunction

endpackage

// ===== src/crcbf_ram.sv =====
// Generic single-port-write, registered-read RAM
module crcbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, and register the read word on a read strobe
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/crcbf_seq.sv =====
// Framing sequencer: turns each input word into a run of byte operations
module crcbf_seq #(
	parameter int MAX_BITS = crcbf_pkg::MAX_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [4:0] block_bits,
	input  logic clr_busy,
	input  logic ready_dn,
	input  logic req_valid,
	output logic req_stall,
	input  logic kind,
	input  logic [7:0] data_byte,
	output logic op_vld,
	output crcbf_pkg::op_t op,
	output logic [MAX_BITS-1:0] op_addr
);

	localparam int DW = MAX_BITS + 1;
	localparam int DEPTH = 2**MAX_BITS - 4;

	typedef enum logic [2:0] {
		PH_OPEN, PH_PAD, PH_LEN, PH_CRC, PH_PAR, PH_PCRC, PH_DONE
	} phase_t;

	logic item_vld_q, item_kind_q;
	logic [7:0] item_byte_q;
	logic [2:0] step_q, hdr_idx_q;
	logic hdr_done_q, first_q;
	logic [MAX_BITS-1:0] fill_q;
	phase_t phase_q;
	logic [DW-1:0] tix_q;

	logic [4:0] eb;
	logic [DW-1:0] ds, bs, fill_x, fill_p1, pad, dadr, etix, tix_n;
	phase_t eph, ph_n;
	logic gen, fin, fin_now, issue, accept;
	logic [2:0] step_n, hdr_idx_n;
	logic hdr_done_n, first_n;
	logic [MAX_BITS-1:0] fill_n;
	crcbf_pkg::op_t o;
	logic [MAX_BITS-1:0] a;

	// Block geometry from the clamped register
	always_comb begin
		if (block_bits < crcbf_pkg::BITS_MIN) begin
			eb = crcbf_pkg::BITS_MIN;
		end else if (block_bits > 5'(MAX_BITS)) begin
			eb = 5'(MAX_BITS);
		end else begin
			eb = block_bits;
		end
		ds = (DW'(1) << eb) - DW'(6);
		bs = ds - (first_q ? DW'(crcbf_pkg::HDR_LEN) : DW'(0));
		fill_x = DW'(fill_q);
		fill_p1 = fill_x + DW'(1);
		pad = (bs > fill_x) ? (bs - fill_x) : DW'(0);
		dadr = fill_x + (first_q ? DW'(crcbf_pkg::HDR_LEN) : DW'(0));
		eph = (phase_q == PH_OPEN) ? PH_PAD : phase_q;
		etix = (phase_q == PH_OPEN) ? DW'(0) : tix_q;
	end

	// Pick the next byte operation and the state it leaves
	always_comb begin
		o = '0;
		o.src = crcbf_pkg::SRC_LIT;
		a = '0;
		gen = 1'b0;
		fin = 1'b0;
		step_n = step_q;
		hdr_idx_n = hdr_idx_q;
		hdr_done_n = hdr_done_q;
		first_n = first_q;
		fill_n = fill_q;
		ph_n = phase_q;
		tix_n = tix_q;
		if (!item_vld_q) begin
			gen = 1'b0;
		end else if (!hdr_done_q && phase_q == PH_OPEN) begin
			gen = 1'b1;
			o.lit = crcbf_pkg::hdr_byte(hdr_idx_q, eb);
			o.framed = 1'b1;
			o.par_we = 1'b1;
			a = MAX_BITS'(hdr_idx_q);
			hdr_idx_n = hdr_idx_q + 3'd1;
			hdr_done_n = (hdr_idx_q == 3'd7);
		end else if (!item_kind_q) begin
			if (phase_q != PH_OPEN) begin
				fin = 1'b1;
			end else begin
				gen = 1'b1;
				case (step_q)
					3'd0: begin
						o.lit = item_byte_q;
						o.framed = 1'b1;
						o.par_we = (dadr < DW'(DEPTH));
						a = MAX_BITS'(dadr);
						fill_n = MAX_BITS'(fill_p1);
						if (fill_p1 >= bs) begin
							step_n = 3'd1;
						end else begin
							o.last = 1'b1;
							fin = 1'b1;
						end
					end
					3'd1: begin
						o.lit = 8'(bs);
						o.framed = 1'b1;
						o.par_we = 1'b1;
						a = MAX_BITS'(ds);
						step_n = 3'd2;
					end
					3'd2: begin
						o.lit = 8'(bs >> 8);
						o.framed = 1'b1;
						o.par_we = 1'b1;
						a = MAX_BITS'(ds + DW'(1));
						step_n = 3'd3;
					end
					default: begin
						o.src = crcbf_pkg::SRC_CRC;
						o.crc_k = 2'(step_q - 3'd3);
						if (step_q == 3'd6) begin
							o.last = 1'b1;
							fin = 1'b1;
							step_n = 3'd0;
							fill_n = '0;
							first_n = 1'b0;
						end else begin
							step_n = step_q + 3'd1;
						end
					end
				endcase
			end
		end else if (phase_q == PH_DONE) begin
			fin = 1'b1;
		end else begin
			gen = 1'b1;
			fin = 1'b1;
			o.last = 1'b1;
			case (eph)
				PH_PAD: begin
					o.framed = 1'b1;
					if (etix < pad) begin
						o.lit = 8'h00;
						ph_n = PH_PAD;
						tix_n = etix + DW'(1);
					end else begin
						o.lit = 8'(fill_q);
						o.par_we = 1'b1;
						a = MAX_BITS'(ds);
						ph_n = PH_LEN;
						tix_n = DW'(1);
					end
				end
				PH_LEN: begin
					if (etix < DW'(2)) begin
						o.lit = (etix == DW'(0)) ? 8'(fill_q) : 8'(fill_x >> 8);
						o.framed = 1'b1;
						o.par_we = 1'b1;
						a = MAX_BITS'(ds + etix);
						tix_n = etix + DW'(1);
					end else begin
						o.src = crcbf_pkg::SRC_CRC;
						ph_n = PH_CRC;
						tix_n = DW'(1);
					end
				end
				PH_CRC: begin
					if (etix < DW'(4)) begin
						o.src = crcbf_pkg::SRC_CRC;
						o.crc_k = 2'(etix);
						tix_n = etix + DW'(1);
					end else begin
						o.src = crcbf_pkg::SRC_PAR;
						o.framed = 1'b1;
						ph_n = PH_PAR;
						tix_n = DW'(1);
					end
				end
				PH_PAR: begin
					if (etix < ds + DW'(2)) begin
						o.src = crcbf_pkg::SRC_PAR;
						o.framed = 1'b1;
						a = MAX_BITS'(etix);
						tix_n = etix + DW'(1);
					end else begin
						o.src = crcbf_pkg::SRC_CRC;
						ph_n = PH_PCRC;
						tix_n = DW'(1);
					end
				end
				default: begin
					o.src = crcbf_pkg::SRC_CRC;
					o.crc_k = 2'(etix);
					if (etix >= DW'(3)) begin
						o.done = 1'b1;
						ph_n = PH_DONE;
						tix_n = '0;
					end else begin
						tix_n = etix + DW'(1);
					end
				end
			endcase
		end
	end

	assign issue = gen && ready_dn;
	assign fin_now = item_vld_q && fin && (!gen || ready_dn);
	assign req_stall = clr_busy || (item_vld_q && !fin_now);
	assign accept = req_valid && !req_stall;
	assign op_vld = gen;
	assign op = o;
	assign op_addr = a;

	// Hold the current word and advance framing state per issued byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_q <= 1'b0;
			item_kind_q <= 1'b0;
			item_byte_q <= '0;
			step_q <= '0;
			hdr_idx_q <= '0;
			hdr_done_q <= 1'b0;
			first_q <= 1'b1;
			fill_q <= '0;
			phase_q <= PH_OPEN;
			tix_q <= '0;
		end else begin
			if (issue || fin_now) begin
				step_q <= step_n;
				hdr_idx_q <= hdr_idx_n;
				hdr_done_q <= hdr_done_n;
				first_q <= first_n;
				fill_q <= fill_n;
				phase_q <= ph_n;
				tix_q <= tix_n;
			end
			if (accept) begin
				item_vld_q <= 1'b1;
				item_kind_q <= kind;
				item_byte_q <= data_byte;
			end else if (fin_now) begin
				item_vld_q <= 1'b0;
			end
		end
	end

endmodule

// ===== src/crcbf_dp.sv =====
// Byte datapath: parity read-modify-write, running CRC, output register
module crcbf_dp #(
	parameter int MAX_BITS = crcbf_pkg::MAX_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic op_vld,
	input  crcbf_pkg::op_t op,
	input  logic [MAX_BITS-1:0] op_addr,
	output logic ready_dn,
	output logic clr_busy,
	output logic ram_we,
	output logic [MAX_BITS-1:0] ram_waddr,
	output logic [7:0] ram_wdata,
	output logic ram_re,
	output logic [MAX_BITS-1:0] ram_raddr,
	input  logic [7:0] ram_rdata,
	output logic rsp_valid,
	input  logic rsp_stall,
	output logic [7:0] out_byte,
	output logic last,
	output logic stream_done
);

	localparam int DEPTH = 2**MAX_BITS - 4;

	logic vld_s1, fwd_s1;
	crcbf_pkg::op_t op_s1;
	logic [MAX_BITS-1:0] addr_s1, clr_q;
	logic [7:0] fwd_d_s1, old_b, b;
	logic [31:0] crc_q;
	logic clr_busy_q, adv, issue, consume, wr_par;

	assign adv = !rsp_valid || !rsp_stall;
	assign ready_dn = !vld_s1 || adv;
	assign issue = op_vld && ready_dn;
	assign consume = vld_s1 && adv;
	assign clr_busy = clr_busy_q;

	// Select the byte of the word in stage 1
	always_comb begin
		old_b = fwd_s1 ? fwd_d_s1 : ram_rdata;
		case (op_s1.src)
			crcbf_pkg::SRC_CRC: b = crc_q[8*op_s1.crc_k +: 8];
			crcbf_pkg::SRC_PAR: b = old_b;
			default: b = op_s1.lit;
		endcase
	end

	// Write back parity, or zero one entry per cycle after reset
	assign wr_par = consume && op_s1.par_we;
	assign ram_we = clr_busy_q || wr_par;
	assign ram_waddr = clr_busy_q ? clr_q : addr_s1;
	assign ram_wdata = clr_busy_q ? 8'h00 : (old_b ^ b);
	assign ram_re = issue;
	assign ram_raddr = op_addr;

	// Advance stage 1, running CRC and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
			fwd_d_s1 <= '0;
			op_s1 <= '0;
			addr_s1 <= '0;
			crc_q <= '0;
			clr_q <= '0;
			clr_busy_q <= 1'b1;
			rsp_valid <= 1'b0;
			out_byte <= '0;
			last <= 1'b0;
			stream_done <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == MAX_BITS'(DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (issue) begin
				vld_s1 <= 1'b1;
				op_s1 <= op;
				addr_s1 <= op_addr;
				fwd_s1 <= wr_par && (addr_s1 == op_addr);
				fwd_d_s1 <= old_b ^ b;
			end else if (consume) begin
				vld_s1 <= 1'b0;
			end
			if (consume) begin
				rsp_valid <= 1'b1;
				out_byte <= b;
				last <= op_s1.last;
				stream_done <= op_s1.done;
				if (op_s1.src == crcbf_pkg::SRC_CRC && op_s1.crc_k == 2'd3) begin
					crc_q <= '0;
				end else if (op_s1.framed) begin
					crc_q <= crcbf_pkg::crc_byte(crc_q, b);
				end
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
		end
	end

endmodule

// ===== src/crc_block_framer_with_xor_parity.sv =====
// Path: an accepted word is registered, then each byte passes stage 1 and the output register.
// Throughput: one output byte per cycle while rsp_stall is low, set by the single byte lane
// through the parity RAM and the CRC; a word makes 1 to 9 bytes, or none, and the next
// word is taken as its last byte issues.
// Reset: control clears at once; then a parity RAM clearing pass over all 2**MAX_BITS-4
// entries runs, during which req_stall is high (register writes still taken).
`include "crc_block_framer_with_xor_parity_assert.svh"
module crc_block_framer_with_xor_parity #(
	parameter int MAX_BITS = crcbf_pkg::MAX_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [4:0] wr_data,
	input  logic req_valid,
	output logic req_stall,
	input  logic kind,
	input  logic [7:0] data_byte,
	output logic rsp_valid,
	input  logic rsp_stall,
	output logic [7:0] out_byte,
	output logic last,
	output logic stream_done
);

	localparam int DEPTH = 2**MAX_BITS - 4;

	logic [4:0] bits_q;
	logic clr_busy, ready_dn, op_vld;
	crcbf_pkg::op_t op;
	logic [MAX_BITS-1:0] op_addr, ram_waddr, ram_raddr;
	logic ram_we, ram_re;
	logic [7:0] ram_wdata, ram_rdata;

	// Hold the block size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= crcbf_pkg::BITS_RESET;
		end else if (wr_en) begin
			bits_q <= wr_data;
		end
	end

	crcbf_seq #(.MAX_BITS(MAX_BITS)) u_seq (
		.clk(clk), .arst_n(arst_n), .block_bits(bits_q), .clr_busy(clr_busy),
		.ready_dn(ready_dn), .req_valid(req_valid), .req_stall(req_stall),
		.kind(kind), .data_byte(data_byte), .op_vld(op_vld), .op(op), .op_addr(op_addr)
	);

	crcbf_dp #(.MAX_BITS(MAX_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .op_vld(op_vld), .op(op), .op_addr(op_addr),
		.ready_dn(ready_dn), .clr_busy(clr_busy), .ram_we(ram_we),
		.ram_waddr(ram_waddr), .ram_wdata(ram_wdata), .ram_re(ram_re),
		.ram_raddr(ram_raddr), .ram_rdata(ram_rdata), .rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall), .out_byte(out_byte), .last(last),
		.stream_done(stream_done)
	);

	crcbf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_par_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
	);

	// Checks on sequencing
	`CRCBF_ASSERT_NOW(a_clr_blocks_input, clr_busy, req_stall, "input taken during clear")
	`CRCBF_ASSERT_NOW(a_done_is_last, rsp_valid && stream_done, last, "final byte not last")
	`CRCBF_ASSERT_NEXT(a_nothing_after_done, rsp_valid && !rsp_stall && stream_done, !rsp_valid, "byte after final byte")
	`CRCBF_ASSERT_NOW(a_no_issue_in_clear, clr_busy, !op_vld, "byte issued during clear")

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the CRC-32C block framer with XOR parity trailer
module testbench;

	localparam int STORE_DEPTH = 65532;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	typedef struct packed {
		logic [7:0] value;
		logic last;
		logic done;
	} frame_byte_t;

	// Predict framed output bytes and compare them in order
	class frame_scoreboard;
		logic [4:0] bits_reg;
		logic [31:0] crc_acc;
		logic [7:0] parity [STORE_DEPTH];
		int unsigned fill;
		bit first_blk;
		bit hdr_sent;
		int unsigned phase;
		int unsigned tidx;
		frame_byte_t pending_q [$];
		int errors;
		int checked;
		bit closed;

		function new();
			bits_reg = crcbf_pkg::BITS_RESET;
			crc_acc = 0;
			foreach (parity[i]) parity[i] = 8'h00;
			fill = 0;
			first_blk = 1;
			hdr_sent = 0;
			phase = 0;
			tidx = 0;
			errors = 0;
			checked = 0;
			closed = 0;
		endfunction

		function void set_bits(logic [4:0] v);
			bits_reg = v;
		endfunction

		function int unsigned eff_bits();
			if (bits_reg < 6) return 6;
			if (bits_reg > 16) return 16;
			return bits_reg;
		endfunction

		function int unsigned data_len();
			return (1 << eff_bits()) - 6;
		endfunction

		function int unsigned block_len();
			return data_len() - (first_blk ? crcbf_pkg::HDR_LEN : 0);
		endfunction

		function logic [31:0] crc32c_step(logic [31:0] acc, logic [7:0] b);
			logic [31:0] c;
			c = ~acc;
			c[7:0] ^= b;
			for (int k = 0; k < 8; k++) begin
				c = c[0] ? ((c >> 1) ^ 32'h82F63B78) : (c >> 1);
			end
			return ~c;
		endfunction

		function void parity_xor(int unsigned idx, logic [7:0] b);
			if (idx < STORE_DEPTH) parity[idx] ^= b;
		endfunction

		function void push_byte(logic [7:0] b, bit d);
			frame_byte_t r;
			r.value = b;
			r.last = 0;
			r.done = d;
			pending_q.push_back(r);
		endfunction

		function void push_framed(logic [7:0] b);
			crc_acc = crc32c_step(crc_acc, b);
			push_byte(b, 0);
		endfunction

		function void push_header();
			int unsigned eb;
			logic [7:0] h [8];
			eb = eff_bits();
			h[0] = "C"; h[1] = "R"; h[2] = "c"; h[3] = " ";
			h[4] = 8'(8'h30 + (eb / 100) % 10);
			h[5] = 8'(8'h30 + (eb / 10) % 10);
			h[6] = 8'(8'h30 + eb % 10);
			h[7] = 8'h0A;
			for (int i = 0; i < 8; i++) begin
				parity_xor(i, h[i]);
				push_framed(h[i]);
			end
			hdr_sent = 1;
		endfunction

		// Advance the trailer by one byte
		function void drain_step();
			int unsigned ds;
			int unsigned pad;
			logic [7:0] b;
			forever begin
				ds = data_len();
				if (phase == 1) begin
					pad = (block_len() > fill) ? block_len() - fill : 0;
					if (tidx < pad) begin
						tidx++;
						push_framed(8'h00);
						return;
					end
					phase = 2; tidx = 0;
				end else if (phase == 2) begin
					if (tidx < 2) begin
						b = (tidx == 0) ? fill[7:0] : fill[15:8];
						parity_xor(ds + tidx, b);
						tidx++;
						push_framed(b);
						return;
					end
					phase = 3; tidx = 0;
				end else if (phase == 3) begin
					if (tidx < 4) begin
						b = 8'(crc_acc >> (8 * tidx));
						tidx++;
						push_byte(b, 0);
						return;
					end
					phase = 4; tidx = 0; crc_acc = 0;
				end else if (phase == 4) begin
					if (tidx < ds + 2) begin
						b = (tidx < STORE_DEPTH) ? parity[tidx] : 8'h00;
						tidx++;
						push_framed(b);
						return;
					end
					phase = 5; tidx = 0;
				end else if (phase == 5) begin
					b = 8'(crc_acc >> (8 * (tidx & 3)));
					tidx++;
					if (tidx >= 4) begin
						phase = 6; tidx = 0;
						closed = 1;
						push_byte(b, 1);
					end else begin
						push_byte(b, 0);
					end
					return;
				end else begin
					return;
				end
			end
		endfunction

		// Note an accepted input word and queue the bytes it makes
		function void note_word(logic k, logic [7:0] b);
			int n0;
			int unsigned ds;
			int unsigned bs;
			logic [31:0] c;
			n0 = pending_q.size();
			if (k == KIND_DATA) begin
				if (phase != 0) return;
				if (!hdr_sent) push_header();
				parity_xor((first_blk ? crcbf_pkg::HDR_LEN : 0) + fill, b);
				push_framed(b);
				fill++;
				if (fill >= block_len()) begin
					ds = data_len();
					bs = block_len();
					parity_xor(ds, bs[7:0]);
					push_framed(bs[7:0]);
					parity_xor(ds + 1, bs[15:8]);
					push_framed(bs[15:8]);
					c = crc_acc;
					for (int i = 0; i < 4; i++) push_byte(8'(c >> (8 * i)), 0);
					crc_acc = 0;
					fill = 0;
					first_blk = 0;
				end
			end else begin
				if (phase >= 6) return;
				if (phase == 0) begin
					if (!hdr_sent) push_header();
					phase = 1;
					tidx = 0;
				end
				drain_step();
			end
			if (pending_q.size() > n0) pending_q[pending_q.size() - 1].last = 1;
		endfunction

		// Check one output byte against the oldest expected one
		function void check_byte(logic [7:0] v, logic l, logic d);
			frame_byte_t e;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected byte %h last %b done %b", $time, v, l, d);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			checked++;
			if (e.value !== v || e.last !== l || e.done !== d) begin
				$display("%0t: expected byte %h last %b done %b, got %h last %b done %b",
					$time, e.value, e.last, e.done, v, l, d);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [4:0] wr_data;
	logic req_valid;
	logic req_stall;
	logic kind;
	logic [7:0] data_byte;
	logic rsp_valid;
	logic rsp_stall;
	logic [7:0] out_byte;
	logic last;
	logic stream_done;

	frame_scoreboard sb;
	int send_idle_pct;
	int stall_pct;
	bit hold_req;
	int cycles;
	int words_sent;

	crc_block_framer_with_xor_parity dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_data(wr_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.kind(kind),
		.data_byte(data_byte),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.out_byte(out_byte),
		.last(last),
		.stream_done(stream_done)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Watch both channels at each edge
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall) sb.note_word(kind, data_byte);
		if (arst_n && rsp_valid && !rsp_stall) sb.check_byte(out_byte, last, stream_done);
	end

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("crc_block_framer_with_xor_parity test failed");
			$finish;
		end
	end

	// Drive the receiver stall, with one long hold-off on request
	initial begin
		rsp_stall = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				rsp_stall <= 1;
				repeat (400) @(posedge clk);
			end
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_word(logic k, logic [7:0] b);
		req_valid <= 1;
		kind <= k;
		data_byte <= b;
		do @(posedge clk); while (req_stall);
		words_sent++;
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
	endtask

	task automatic write_bits(logic [4:0] v);
		req_valid <= 0;
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		wr_en <= 1;
		wr_data <= v;
		@(posedge clk);
		wr_en <= 0;
		sb.set_bits(v);
	endtask

	task automatic send_random(int count);
		for (int i = 0; i < count; i++) send_word(KIND_DATA, $urandom_range(255));
	endtask

	initial begin
		logic [7:0] edge_bytes [8];
		sb = new();
		cycles = 0;
		words_sent = 0;
		hold_req = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		arst_n = 0;
		wr_en = 0;
		wr_data = 0;
		req_valid = 0;
		kind = KIND_DATA;
		data_byte = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed words, no idling
		wr_en <= 1;
		wr_data <= 5'd7;
		@(posedge clk);
		wr_en <= 0;
		sb.set_bits(5'd7);
		edge_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'hFE};
		foreach (edge_bytes[i]) send_word(KIND_DATA, edge_bytes[i]);
		for (int i = 0; i < 12; i++) send_word(KIND_DATA, 8'h01 << (i % 8));

		// Smallest blocks via an under-range setting; sender mostly idle
		write_bits(5'd0);
		send_idle_pct = 80;
		send_random(30);

		// Over-range setting; receiver stalls, with one long hold-off
		write_bits(5'd31);
		send_idle_pct = 0;
		stall_pct = 80;
		hold_req = 1;
		send_random(20);

		// Both sides idle a little
		write_bits(5'd6);
		send_idle_pct = 15;
		stall_pct = 15;
		send_random(20);

		// Drain the trailer, slipping in ignored data words
		while (!sb.closed) begin
			if ($urandom_range(9) == 0) send_word(KIND_DATA, $urandom_range(255));
			else send_word(KIND_DRAIN, $urandom_range(255));
		end
		send_word(KIND_DRAIN, 8'h00);
		send_word(KIND_DATA, 8'h5A);
		send_word(KIND_DRAIN, 8'hFF);
		req_valid <= 0;

		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		$display("Covered %0d words and %0d bytes over block sizes 6, 7 and 16,",
			words_sent, sb.checked);
		$display("including a full trailer drain and words after the stream closed.");
		if (sb.errors == 0) begin
			$display("crc_block_framer_with_xor_parity test passed");
		end else begin
			$display("crc_block_framer_with_xor_parity test failed");
		end
		$finish;
	end
endmodule
